// File: src/assert_macros.svh
// Assertion macros shared by the operator RTL.
// No dependencies; included by the top level only.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk, skipped while rst is high.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition never holds on a rising edge of clk.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// File: src/fmop_pkg.sv
// Shared types, widths and constants of the FM operator.
// No dependencies; imported by the controller, datapath and top level.
package fmop_pkg;

  localparam int unsigned PHASE_BITS_DEF      = 32;
  localparam int unsigned SINE_INDEX_BITS_DEF = 10;
  localparam int unsigned FRAC_BITS_DEF       = 15;

  localparam int unsigned KIND_W     = 2;
  localparam int unsigned MOD_W      = 16;
  localparam int unsigned STEP_W     = 32;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned AMP_W      = 17;
  localparam int unsigned RATE_W     = 15;
  localparam int unsigned LEVEL_W    = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned S_TDATA_W  = 48;
  localparam int unsigned M_TDATA_W  = 24;

  // Shared multiplier: 33-bit signed by 18-bit signed.
  localparam int unsigned MUL_A_W = 33;
  localparam int unsigned MUL_B_W = 18;
  localparam int unsigned PROD_W  = 51;

  // Quarter-wave polynomial coefficients, Q15.
  localparam int unsigned SIN_A = 51472;
  localparam int unsigned SIN_B = 21167;
  localparam int unsigned SIN_C = 2605;

  // Item kinds carried in tuser.
  localparam logic [KIND_W-1:0] KIND_TICK    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_KEY_ON  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_KEY_OFF = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ENV_ENABLE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_RATE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_RATE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_RATE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_RATE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_LEVEL   = 3'd5;

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_ATTACK  = 5'b00010,
    ST_DECAY   = 5'b00100,
    ST_HOLD    = 5'b01000,
    ST_RELEASE = 5'b10000
  } env_stage_t;

  typedef enum logic [1:0] {
    ENV_PASS,
    ENV_ZERO,
    ENV_SCALE
  } env_mode_t;

  typedef enum logic [2:0] {
    MUL_PHASE,
    MUL_TT,
    MUL_CT,
    MUL_TI,
    MUL_TS,
    MUL_ENV
  } mul_sel_t;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     phase_en;
    logic     t_en;
    logic     t2_en;
    logic     osc_en;
    logic     out_load;
  } fmop_cmd_t;

  typedef struct packed {
    logic in_tick;
  } fmop_sts_t;

endpackage

// File: src/fmop_ctrl.sv
// Sequencer of the FM operator: steps the shared multiplier through one tick.
// Depends on fmop_pkg for command and status types.
module fmop_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  output logic                m_tvalid,
  input  logic                m_tready,
  input  fmop_pkg::fmop_sts_t sts,
  output fmop_pkg::fmop_cmd_t cmd
);
  import fmop_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_MPH  = 10'b0000000010,
    S_PADD = 10'b0000000100,
    S_MTT  = 10'b0000001000,
    S_MC   = 10'b0000010000,
    S_MI   = 10'b0000100000,
    S_MS   = 10'b0001000000,
    S_OSC  = 10'b0010000000,
    S_ME   = 10'b0100000000,
    S_OUT  = 10'b1000000000
  } ctrl_state_t;

  ctrl_state_t state;
  ctrl_state_t state_next;
  logic        out_free;

  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next   = state;
    s_tready     = 1'b0;
    cmd          = '0;
    cmd.mul_sel  = MUL_PHASE;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = sts.in_tick ? S_MPH : S_OUT;
        end
      end
      S_MPH: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_PHASE;
        state_next  = S_PADD;
      end
      S_PADD: begin
        cmd.phase_en = 1'b1;
        state_next   = S_MTT;
      end
      S_MTT: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_TT;
        cmd.t_en    = 1'b1;
        state_next  = S_MC;
      end
      S_MC: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_CT;
        cmd.t2_en   = 1'b1;
        state_next  = S_MI;
      end
      S_MI: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_TI;
        state_next  = S_MS;
      end
      S_MS: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_TS;
        state_next  = S_OSC;
      end
      S_OSC: begin
        cmd.osc_en = 1'b1;
        state_next = S_ME;
      end
      S_ME: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_ENV;
        state_next  = S_OUT;
      end
      S_OUT: begin
        // hold until the output register is free
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

// File: src/fmop_datapath.sv
// Datapath of the FM operator: config registers, phase, envelope, sine
// polynomial on one shared multiplier, output register. Uses fmop_pkg.
module fmop_datapath #(
  parameter int unsigned PHASE_BITS      = fmop_pkg::PHASE_BITS_DEF,
  parameter int unsigned SINE_INDEX_BITS = fmop_pkg::SINE_INDEX_BITS_DEF,
  parameter int unsigned FRAC_BITS       = fmop_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [fmop_pkg::S_TDATA_W-1:0]    s_tdata,
  input  logic [fmop_pkg::KIND_W-1:0]       s_tuser,
  input  logic                              cfg_we,
  input  logic [fmop_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fmop_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  fmop_pkg::fmop_cmd_t               cmd,
  output fmop_pkg::fmop_sts_t               sts,
  output logic [fmop_pkg::M_TDATA_W-1:0]    m_tdata
);
  import fmop_pkg::*;

  localparam int unsigned QB        = SINE_INDEX_BITS - 2;
  localparam int unsigned SHIFT_T   = 15 - QB;
  localparam int unsigned OSC_SHIFT = 15 - FRAC_BITS;
  localparam int unsigned ENV_W     = AMP_W + 1;

  localparam logic [QB:0]                  QFULL   = {1'b1, {QB{1'b0}}};
  localparam logic signed [ENV_W-1:0]      ONE_Q   = ENV_W'(1 << FRAC_BITS);
  localparam logic signed [PROD_W-1:0]     SAT_HI  = PROD_W'(32767);
  localparam logic signed [PROD_W-1:0]     SAT_LO  = -PROD_W'(32768);

  // configuration
  logic               env_en;
  logic [RATE_W-1:0]  attack_rate;
  logic [RATE_W-1:0]  decay_rate;
  logic [RATE_W-1:0]  hold_rate;
  logic [RATE_W-1:0]  release_rate;
  logic [LEVEL_W-1:0] hold_level;

  // operator state
  logic [PHASE_BITS-1:0]  phase;
  logic [STEP_W-1:0]      step;
  logic [AMP_W-1:0]       amp;
  env_stage_t             stage;
  logic signed [SAMPLE_W-1:0] last_sample;
  logic                   tick_reg;

  // working registers
  logic signed [MOD_W-1:0]    mod_reg;
  env_mode_t                  env_mode;
  logic signed [PROD_W-1:0]   prod;
  logic [15:0]                t_reg;
  logic [1:0]                 quad_reg;
  logic [15:0]                t2_reg;
  logic signed [SAMPLE_W-1:0] osc_reg;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic                       out_active;

  // input fields
  logic signed [MOD_W-1:0] in_mod;
  logic [STEP_W-1:0]       in_step;

  assign in_mod      = s_tdata[MOD_W-1:0];
  assign in_step     = s_tdata[MOD_W +: STEP_W];
  assign sts.in_tick = (s_tuser == KIND_TICK);

  always_ff @(posedge clk) begin
    if (rst) begin
      env_en       <= 1'b0;
      attack_rate  <= '0;
      decay_rate   <= '0;
      hold_rate    <= '0;
      release_rate <= '0;
      hold_level   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ENV_ENABLE:   env_en       <= cfg_data[0];
        CFG_ATTACK_RATE:  attack_rate  <= cfg_data[RATE_W-1:0];
        CFG_DECAY_RATE:   decay_rate   <= cfg_data[RATE_W-1:0];
        CFG_HOLD_RATE:    hold_rate    <= cfg_data[RATE_W-1:0];
        CFG_RELEASE_RATE: release_rate <= cfg_data[RATE_W-1:0];
        CFG_HOLD_LEVEL:   hold_level   <= cfg_data[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // envelope step for one tick
  logic signed [ENV_W-1:0] amp_ext;
  logic signed [ENV_W-1:0] rate_ext;
  logic signed [ENV_W-1:0] amp_sum;
  logic signed [ENV_W-1:0] level_ext;
  logic signed [ENV_W-1:0] amp_work;
  env_stage_t              st_work;
  env_stage_t              stage_next;
  logic [AMP_W-1:0]        amp_next;
  env_mode_t               mode_next;

  assign amp_ext   = ENV_W'(amp);
  assign level_ext = ENV_W'(hold_level);
  assign amp_sum   = amp_ext + rate_ext;

  always_comb begin
    case (stage)
      ST_ATTACK: rate_ext = ENV_W'(attack_rate);
      ST_DECAY:  rate_ext = -ENV_W'(decay_rate);
      ST_HOLD:   rate_ext = -ENV_W'(hold_rate);
      default:   rate_ext = -ENV_W'(release_rate);
    endcase
  end

  always_comb begin
    stage_next = stage;
    amp_next   = amp;
    mode_next  = ENV_SCALE;
    st_work    = stage;
    amp_work   = amp_sum;
    if (!env_en) begin
      mode_next = ENV_PASS;
      if (stage == ST_RELEASE) begin
        stage_next = ST_IDLE;
      end
    end else if (stage == ST_IDLE) begin
      mode_next = ENV_ZERO;
    end else if (amp_sum <= 0) begin
      stage_next = ST_IDLE;
      amp_next   = '0;
      mode_next  = ENV_ZERO;
    end else begin
      if (stage == ST_ATTACK && amp_sum >= ONE_Q) begin
        amp_work = ONE_Q;
        st_work  = ST_DECAY;
      end
      if (st_work == ST_DECAY && amp_work <= level_ext) begin
        amp_work = level_ext;
        st_work  = ST_HOLD;
      end
      stage_next = st_work;
      amp_next   = amp_work[AMP_W-1:0];
    end
  end

  // sine index and mirrored quarter-wave position
  logic [SINE_INDEX_BITS-1:0] idx;
  logic [1:0]                 quad;
  logic [QB-1:0]              pos;
  logic [QB:0]                posm;
  logic [15:0]                t_cur;

  assign idx   = phase[PHASE_BITS-1 -: SINE_INDEX_BITS];
  assign quad  = idx[SINE_INDEX_BITS-1 -: 2];
  assign pos   = idx[QB-1:0];
  assign posm  = quad[0] ? (QFULL - {1'b0, pos}) : {1'b0, pos};
  assign t_cur = {posm, {SHIFT_T{1'b0}}};

  // shared multiplier operand select
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  mul_p;

  always_comb begin
    case (cmd.mul_sel)
      MUL_PHASE: begin
        mul_a = MUL_A_W'(step);
        mul_b = MUL_B_W'(mod_reg) + ONE_Q;
      end
      MUL_TT: begin
        mul_a = MUL_A_W'(t_cur);
        mul_b = MUL_B_W'(t_cur);
      end
      MUL_CT: begin
        mul_a = MUL_A_W'(SIN_C);
        mul_b = MUL_B_W'(prod[30:15]);
      end
      MUL_TI: begin
        mul_a = MUL_A_W'(t2_reg);
        mul_b = MUL_B_W'(SIN_B) - MUL_B_W'(prod[26:15]);
      end
      MUL_TS: begin
        mul_a = MUL_A_W'(t_reg);
        mul_b = MUL_B_W'(SIN_A) - MUL_B_W'(prod[29:15]);
      end
      MUL_ENV: begin
        mul_a = MUL_A_W'(osc_reg);
        mul_b = MUL_B_W'(amp);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // sine from the final polynomial product: saturate, scale, sign by quadrant
  logic [15:0]                s_raw;
  logic [14:0]                s_mag;
  logic [14:0]                s_shift;
  logic signed [SAMPLE_W-1:0] osc_next;

  assign s_raw    = prod[30:15];
  assign s_mag    = s_raw[15] ? 15'h7FFF : s_raw[14:0];
  assign s_shift  = s_mag >> OSC_SHIFT;
  assign osc_next = quad_reg[1] ? -SAMPLE_W'(s_shift) : SAMPLE_W'(s_shift);

  // floor of the product by one, shared by phase update and envelope scaling
  logic signed [PROD_W-1:0]   prod_q;
  logic signed [SAMPLE_W-1:0] result;

  assign prod_q = prod >>> FRAC_BITS;

  always_comb begin
    case (env_mode)
      ENV_PASS:  result = osc_reg;
      ENV_ZERO:  result = '0;
      ENV_SCALE: begin
        if (prod_q > SAT_HI) begin
          result = SAT_HI[SAMPLE_W-1:0];
        end else if (prod_q < SAT_LO) begin
          result = SAT_LO[SAMPLE_W-1:0];
        end else begin
          result = prod_q[SAMPLE_W-1:0];
        end
      end
      default:   result = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= '0;
      step        <= '0;
      amp         <= '0;
      stage       <= ST_IDLE;
      last_sample <= '0;
      tick_reg    <= 1'b0;
    end else begin
      if (cmd.load) begin
        tick_reg <= sts.in_tick;
        case (s_tuser)
          KIND_TICK: begin
            amp   <= amp_next;
            stage <= stage_next;
          end
          KIND_KEY_ON: begin
            step  <= in_step;
            phase <= '0;
            amp   <= '0;
            stage <= ST_ATTACK;
          end
          KIND_KEY_OFF: begin
            if (stage != ST_IDLE) begin
              stage <= ST_RELEASE;
            end
          end
          default: ;
        endcase
      end
      if (cmd.phase_en) begin
        phase <= phase + prod_q[PHASE_BITS-1:0];
      end
      if (cmd.out_load && tick_reg) begin
        last_sample <= result;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mod_reg  <= in_mod;
      env_mode <= mode_next;
    end
    if (cmd.mul_en) begin
      prod <= mul_p;
    end
    if (cmd.t_en) begin
      t_reg    <= t_cur;
      quad_reg <= quad;
    end
    if (cmd.t2_en) begin
      t2_reg <= prod[30:15];
    end
    if (cmd.osc_en) begin
      osc_reg <= osc_next;
    end
    if (cmd.out_load) begin
      out_sample <= tick_reg ? result : last_sample;
      out_active <= (stage != ST_IDLE);
    end
  end

  assign m_tdata = M_TDATA_W'({out_active, out_sample});

endmodule

// File: src/fm_operator_with_envelope_core.sv
// FM operator core. A tick walks the multiplier schedule before its result
// is loaded into the output register; key on/off and unused kinds go straight
// to the output load. No new beat is taken before the last result is loaded;
// the tick time is set by six dependent products on one shared 33x18 multiplier.
// Reset: rst (synchronous, active high) clears config, phase, step, envelope
// and the held sample, and drops the output beat.
`include "assert_macros.svh"

module fm_operator_with_envelope_core #(
  parameter int unsigned PHASE_BITS      = fmop_pkg::PHASE_BITS_DEF,
  parameter int unsigned SINE_INDEX_BITS = fmop_pkg::SINE_INDEX_BITS_DEF,
  parameter int unsigned FRAC_BITS       = fmop_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // slave side
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [fmop_pkg::S_TDATA_W-1:0]  s_tdata,   // [15:0] modulation, [47:16] phase_step
  input  logic [fmop_pkg::KIND_W-1:0]     s_tuser,   // [1:0] kind
  // master side
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [fmop_pkg::M_TDATA_W-1:0]  m_tdata,   // [15:0] sample, [16] active, zero fill
  // configuration writes
  input  logic                            cfg_we,
  input  logic [fmop_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fmop_pkg::CFG_DATA_W-1:0] cfg_data
);
  import fmop_pkg::*;

  fmop_cmd_t cmd;
  fmop_sts_t sts;

  // Controller: takes a beat only when idle, walks the multiplier schedule
  // for a tick (phase step, t*t, C*t2, t2*inner, t*inner2, sine*amplitude),
  // then holds the result until the output register is free. A new beat is
  // taken while the previous result still waits on the master side.
  fmop_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: config registers, phase accumulator, envelope stage and level
  // (updated in the accept cycle of a tick), sine polynomial and the output
  // register that keeps the master payload stable while it waits.
  fmop_datapath #(
    .PHASE_BITS      (PHASE_BITS),
    .SINE_INDEX_BITS (SINE_INDEX_BITS),
    .FRAC_BITS       (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .m_tdata   (m_tdata)
  );

  // Never load the output register over a beat that is still waiting.
  `ASSERT_NEVER(a_no_overwrite, cmd.out_load && m_tvalid && !m_tready, "output beat overwritten")
  // The block works on one item at a time: busy right after a beat is taken.
  `ASSERT_CLK(a_busy_after_accept, (s_tvalid && s_tready) |=> !s_tready, "second beat taken while busy")
  // Input registers load only on a completed slave handshake.
  `ASSERT_CLK(a_load_on_beat, cmd.load |-> (s_tvalid && s_tready), "load without input beat")

endmodule
